### sv/bgr_pkg.sv
// Shared types and constants of the bitmap glyph row renderer.
package bgr_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_DRAW      = 2'd0;
    localparam logic [1:0] OP_WR_FACE   = 2'd1;
    localparam logic [1:0] OP_WR_OFFSET = 2'd2;
    localparam logic [1:0] OP_WR_WIDTH  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_FONT = 3'd4;
    localparam int unsigned CFG_DATA_W = 8;

    // Widest face address any legal font size needs.
    localparam int unsigned CMD_ADDR_W = 16;
    localparam int unsigned MASK_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BANKS      = 4;
    localparam int unsigned CMD_DEPTH  = 4;
    localparam int unsigned OUT_DEPTH  = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] table_address;
        logic [11:0] table_data;
        logic [7:0]  char_code;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic [7:0]  ink_color;
    } t_in;

    typedef struct packed {
        logic [11:0] row_x;
        logic [11:0] row_y;
        logic [31:0] pixel_mask;
        logic [7:0]  pixel_color;
        logic [7:0]  advance_width;
        logic        ok;
        logic        last_row;
    } t_out;

    typedef struct packed {
        logic [5:0] cell_width;
        logic [5:0] cell_height;
        logic [7:0] first_code;
        logic [7:0] char_count;
        logic       complex_font;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_FACE,
        CMD_DRAW,
        CMD_MISS
    } t_cmd_kind;

    // Work handed from the front to the back. For a face write, addr_off is the
    // face address and data the byte; for a draw, the glyph start offset and width.
    typedef struct packed {
        t_cmd_kind             kind;
        logic [CMD_ADDR_W-1:0] addr_off;
        logic [7:0]            data;
        logic [11:0]           screen_x;
        logic [11:0]           screen_y;
        logic [7:0]            ink_color;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_DRAW
    } t_bk_state;

endpackage

### sv/bgr_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module bgr_fifo #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    output logic                     o_full,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_data,
    output logic                     o_empty,
    output logic [$clog2(DEPTH):0]   o_count
);
    localparam int unsigned PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/bgr_front.sv
// Front end: accepts items, keeps the offset and width tables, classifies draws.
module bgr_front #(
    parameter int unsigned CODE_SLOTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bgr_pkg::t_cfg i_cfg,
    input  logic          i_push,
    input  bgr_pkg::t_in  i_item,
    output logic          o_full,
    output logic          o_cmd_push,
    output bgr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_full
);
    import bgr_pkg::*;

    localparam int unsigned SW = $clog2(CODE_SLOTS);

    logic [11:0] r_off_tab [CODE_SLOTS];
    logic [7:0]  r_wid_tab [CODE_SLOTS];

    logic        r_s1_valid;
    t_in         r_s1_item;
    logic        r_s1_present;
    logic [7:0]  r_s1_idx;
    logic [11:0] r_off_q;
    logic [7:0]  r_wid_q;

    logic        accept;
    logic        s1_done;
    logic        s1_queued;
    logic        present;
    logic [7:0]  idx;
    logic [8:0]  code_end;
    logic [13:0] simple_off;

    assign o_full    = r_s1_valid && i_cmd_full;
    assign accept    = i_push && !o_full;
    assign s1_done   = r_s1_valid && !i_cmd_full;
    // Table writes finish here; only draws and face writes go on to the back.
    assign s1_queued = (r_s1_item.operation == OP_DRAW) ||
                       (r_s1_item.operation == OP_WR_FACE);
    assign o_cmd_push = s1_done && s1_queued;

    assign code_end = {1'b0, i_cfg.first_code} + {1'b0, i_cfg.char_count};
    assign present  = (i_item.char_code >= i_cfg.first_code) &&
                      ({1'b0, i_item.char_code} < code_end);
    assign idx      = i_item.char_code - i_cfg.first_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item    <= i_item;
            r_s1_present <= present;
            r_s1_idx     <= idx;
        end
    end

    // Both tables are written and read only when an item is accepted, so a
    // stalled draw keeps the entries it looked up.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_item.operation == OP_WR_OFFSET) begin
                r_off_tab[i_item.table_address[SW-1:0]] <= i_item.table_data;
            end
            if (i_item.operation == OP_WR_WIDTH) begin
                r_wid_tab[i_item.table_address[SW-1:0]] <= i_item.table_data[7:0];
            end
            r_off_q <= r_off_tab[idx[SW-1:0]];
            r_wid_q <= r_wid_tab[idx[SW-1:0]];
        end
    end

    assign simple_off = {6'd0, r_s1_idx} * {8'd0, i_cfg.cell_height};

    always_comb begin
        o_cmd.screen_x  = r_s1_item.screen_x;
        o_cmd.screen_y  = r_s1_item.screen_y;
        o_cmd.ink_color = r_s1_item.ink_color;
        if (r_s1_item.operation == OP_WR_FACE) begin
            o_cmd.kind     = CMD_FACE;
            o_cmd.addr_off = CMD_ADDR_W'(r_s1_item.table_address);
            o_cmd.data     = r_s1_item.table_data[7:0];
        end else if (!r_s1_present) begin
            o_cmd.kind     = CMD_MISS;
            o_cmd.addr_off = '0;
            o_cmd.data     = '0;
        end else if (i_cfg.complex_font) begin
            o_cmd.kind     = CMD_DRAW;
            o_cmd.addr_off = CMD_ADDR_W'(r_off_q);
            o_cmd.data     = r_wid_q;
        end else begin
            o_cmd.kind     = CMD_DRAW;
            o_cmd.addr_off = CMD_ADDR_W'(simple_off);
            o_cmd.data     = 8'(i_cfg.cell_width);
        end
    end

endmodule

### sv/bgr_back.sv
// Back end: holds the banked face memory and renders one glyph row per cycle while the result queue has room.
module bgr_back #(
    parameter int unsigned MAX_WIDTH  = 32,
    parameter int unsigned MAX_ROWS   = 32,
    parameter int unsigned FACE_BYTES = 4096,
    parameter int unsigned OUT_DEPTH  = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bgr_pkg::t_cfg               i_cfg,
    input  bgr_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH):0]  i_out_count,
    output logic                        o_out_push,
    output bgr_pkg::t_out               o_out
);
    import bgr_pkg::*;

    localparam int unsigned AW      = $clog2(FACE_BYTES);
    localparam int unsigned BANK_D  = FACE_BYTES / BANKS;
    localparam int unsigned CW      = $clog2(OUT_DEPTH) + 1;
    localparam int unsigned COL_CAP = (MAX_WIDTH < MASK_W) ? MAX_WIDTH : MASK_W;
    localparam int unsigned ROW_CAP = (MAX_ROWS < 32) ? MAX_ROWS : 32;

    t_bk_state   r_state;
    t_bk_state   n_state;

    logic [AW-1:0]     r_off;
    logic [7:0]        r_width;
    logic [11:0]       r_sx;
    logic [11:0]       r_sy;
    logic [7:0]        r_ink;
    logic [4:0]        r_row;
    logic [4:0]        r_last_row;
    logic [2:0]        r_stride;
    logic [MASK_W-1:0] r_xmask;

    logic        r_b_valid;
    logic        r_b_miss;
    logic        r_b_last;
    logic [11:0] r_b_y;
    logic [1:0]  r_b_lo;
    logic [7:0]  r_bank_q [BANKS];

    logic              space;
    logic              face_we;
    logic              load;
    logic              issue_row;
    logic              issue_miss;
    logic [5:0]        cols;
    logic [5:0]        rows;
    logic [3:0]        used;
    logic [2:0]        stride;
    logic [MASK_W-1:0] xmask;
    logic [MASK_W-1:0] raw;
    logic [AW-1:0]     face_waddr;

    // Room for one more result counts the row already read but not yet queued.
    assign space = ({1'b0, i_out_count} + (CW+1)'(r_b_valid)) < (CW+1)'(OUT_DEPTH);

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        face_we    = 1'b0;
        load       = 1'b0;
        issue_row  = 1'b0;
        issue_miss = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        CMD_FACE: begin
                            face_we   = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        CMD_MISS: begin
                            if (space) begin
                                issue_miss = 1'b1;
                                o_cmd_pop  = 1'b1;
                            end
                        end
                        CMD_DRAW: begin
                            load      = 1'b1;
                            o_cmd_pop = 1'b1;
                            n_state   = BK_DRAW;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_DRAW: begin
                if (space) begin
                    issue_row = 1'b1;
                    if (r_row == r_last_row) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Per-draw geometry: which face bytes a row uses and which mask bits survive.
    assign cols = (i_cfg.cell_width > 6'(COL_CAP)) ? 6'(COL_CAP) : i_cfg.cell_width;
    assign rows = (i_cfg.cell_height == '0) ? 6'd1 :
                  (i_cfg.cell_height > 6'(ROW_CAP)) ? 6'(ROW_CAP) : i_cfg.cell_height;

    always_comb begin
        for (int k = 0; k < BANKS; k++) begin
            used[k] = (cols > 6'(8 * k)) && ((k == 0) || (i_cmd.data > 8'(8 * k)));
        end
        for (int x = 0; x < MASK_W; x++) begin
            xmask[x] = (6'(x) < cols) && used[x / 8];
        end
        // A row moves on one byte, plus one at every byte boundary that the cell reaches and
        // the character width passes, even when no byte follows in the row.
        stride = 3'd1;
        for (int k = 1; k <= BANKS; k++) begin
            stride = stride + 3'((cols >= 6'(8 * k)) && (i_cmd.data > 8'(8 * k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_off      <= AW'(i_cmd.addr_off);
            r_width    <= i_cmd.data;
            r_sx       <= i_cmd.screen_x;
            r_sy       <= i_cmd.screen_y;
            r_ink      <= i_cmd.ink_color;
            r_row      <= '0;
            r_last_row <= 5'(rows - 6'd1);
            r_stride   <= stride;
            r_xmask    <= xmask;
        end else if (issue_row) begin
            r_off <= r_off + AW'(r_stride);
            r_row <= r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue_row || issue_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_row || issue_miss) begin
            r_b_miss <= issue_miss;
            r_b_last <= issue_miss || (r_row == r_last_row);
            r_b_y    <= r_sy + 12'(r_row);
            r_b_lo   <= r_off[1:0];
        end
    end

    // Four banks interleaved on the low address bits give the four consecutive
    // bytes of a row in a single read.
    assign face_waddr = AW'(i_cmd.addr_off);

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [7:0]    r_bank [BANK_D];
        logic [1:0]    rd_k;
        logic [AW-1:0] rd_addr;

        assign rd_k    = 2'(b) - r_off[1:0];
        assign rd_addr = r_off + AW'(rd_k);

        always_ff @(posedge i_clk) begin
            if (face_we && (face_waddr[1:0] == 2'(b))) begin
                r_bank[face_waddr[AW-1:2]] <= i_cmd.data;
            end
            if (issue_row) begin
                r_bank_q[b] <= r_bank[rd_addr[AW-1:2]];
            end
        end
    end

    // Face bytes are MSB first: bit 7 of byte k is pixel 8k.
    always_comb begin
        for (int k = 0; k < BANKS; k++) begin
            for (int j = 0; j < BYTE_W; j++) begin
                raw[8 * k + j] = r_bank_q[2'(k) + r_b_lo][7 - j];
            end
        end
    end

    assign o_out_push = r_b_valid;

    always_comb begin
        if (r_b_miss) begin
            o_out            = '0;
            o_out.last_row   = 1'b1;
        end else begin
            o_out.row_x         = r_sx;
            o_out.row_y         = r_b_y;
            o_out.pixel_mask    = raw & r_xmask;
            o_out.pixel_color   = r_ink;
            o_out.advance_width = r_width;
            o_out.ok            = 1'b1;
            o_out.last_row      = r_b_last;
        end
    end

endmodule

### sv/bitmap_glyph_row_renderer.sv
// Bitmap glyph row renderer: top level with configuration registers and queues.
// Load items write face bytes, per-character offsets and widths; a draw item gives one
// result per glyph row (cell_height rows, held to 1..MAX_ROWS, at most 32), or a single
// result with ok clear when the code is outside the font. The front takes one item per
// cycle unless its held item waits on a full command queue, and hands draws and face
// writes to the back through a four-entry command queue; offset and width writes finish
// in the front. The back writes a face byte or answers an absent code from idle; a draw
// loads its command, then gives one row a cycle, set by the four interleaved face banks
// each giving one byte per cycle. Results wait in a four-entry queue; the back pauses when
// that queue has no room. Configuration may be written only while no item is in flight.
module bitmap_glyph_row_renderer #(
    parameter int unsigned MAX_WIDTH  = 32,
    parameter int unsigned MAX_ROWS   = 32,
    parameter int unsigned FACE_BYTES = 4096,
    parameter int unsigned CODE_SLOTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bgr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  bgr_pkg::t_in                      i_item,
    output logic                              empty,
    input  logic                              pop,
    output bgr_pkg::t_out                     o_result
);
    import bgr_pkg::*;

    localparam int unsigned CCW = $clog2(CMD_DEPTH) + 1;
    localparam int unsigned OCW = $clog2(OUT_DEPTH) + 1;

    t_cfg           r_cfg;
    logic           cmd_push;
    t_cmd           cmd_in;
    logic           cmd_full;
    logic           cmd_pop;
    t_cmd           cmd_out;
    logic           cmd_empty;
    logic [CCW-1:0] cmd_count;
    logic           out_push;
    t_out           out_in;
    logic           out_full;
    logic [OCW-1:0] out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_width   <= 6'd8;
            r_cfg.cell_height  <= 6'd8;
            r_cfg.first_code   <= '0;
            r_cfg.char_count   <= '0;
            r_cfg.complex_font <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_CELL_WIDTH:   r_cfg.cell_width   <= i_cfg_data[5:0];
                CFG_CELL_HEIGHT:  r_cfg.cell_height  <= i_cfg_data[5:0];
                CFG_FIRST_CODE:   r_cfg.first_code   <= i_cfg_data;
                CFG_CHAR_COUNT:   r_cfg.char_count   <= i_cfg_data;
                CFG_COMPLEX_FONT: r_cfg.complex_font <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bgr_front #(
        .CODE_SLOTS (CODE_SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    bgr_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    bgr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_ROWS   (MAX_ROWS),
        .FACE_BYTES (FACE_BYTES),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out       (out_in)
    );

    bgr_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_out))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );

`ifndef ASSERT_OFF
    // The front must hold an item rather than push into a full command queue.
    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_push && cmd_full))
        else $error("command queue overflow");

    // The back's room check must keep the result queue from overflowing.
    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_push && out_full))
        else $error("result queue overflow");

    // The back takes a command only when one is waiting.
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> (cmd_count != '0))
        else $error("command popped from an empty queue");

    // An absent code always closes its draw.
    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.ok || o_result.last_row))
        else $error("result without ok that does not end its draw");
`endif

endmodule
